// ----- hw/rtl/wbps_pkg.sv -----
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants for the wildcard byte pattern scanner
// Holds the payload structs of both channels, the configuration register
// indexes and the default sizes handed to the top level.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_PATTERN_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;

  // Pattern storage is fixed at sixteen bytes by the register map.
  localparam int SIG_BYTES    = 16;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 2;
  localparam int CARE_W       = 16;
  localparam int LEN_FIELD_W  = 5;
  localparam int OUT_OFFSET_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CARE_MASK    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 2'd3;

  // One input transfer: a byte of the scanned region.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } wbps_in_t;

  // One result transfer, given on the last byte of a region.
  typedef struct packed {
    logic                    found;
    logic [OUT_OFFSET_W-1:0] match_offset;
  } wbps_out_t;

  // Pattern settings seen by the compare logic.
  typedef struct packed {
    logic [SIG_BYTES*8-1:0] pattern;
    logic [CARE_W-1:0]      care_mask;
  } wbps_sig_t;

endpackage

// ----- hw/rtl/wbps_window.sv -----
// ----------------------------------------------------------------------------
// wbps_window: byte window and masked pattern compare
// Shifts each accepted byte into a window of the newest bytes and compares
// the shifted window with the pattern wherever the care mask is set.
// ----------------------------------------------------------------------------
module wbps_window
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  wbps_sig_t        sig,
  input  logic [LEN_W-1:0] eff_len,
  output logic             hit
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int NCMP  = (MAX_PATTERN < SIG_BYTES) ? MAX_PATTERN : SIG_BYTES;

  logic [7:0]      window [MAX_PATTERN];
  logic [7:0]      window_shift [MAX_PATTERN];
  logic [NCMP-1:0] byte_ok;

  // Window after the new byte enters; entry 0 is the newest byte.
  always_comb begin
    window_shift[0] = data_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      window_shift[i] = window[i-1];
    end
  end

  // Pattern byte k lines up with the byte that arrived len-1-k steps ago.
  for (genvar k = 0; k < NCMP; k++) begin : g_cmp
    logic [LEN_W-1:0] pos;
    logic             in_use;
    assign pos     = eff_len - LEN_W'(k + 1);
    assign in_use  = eff_len > LEN_W'(k);
    assign byte_ok[k] = !in_use || !sig.care_mask[k] ||
                        (window_shift[pos[IDX_W-1:0]] == sig.pattern[8*k +: 8]);
  end

  // Positions beyond the sixteen stored bytes are wildcards.
  assign hit = &byte_ok;

  // Window register: shift on every transfer, clear at the end of a region.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window[i] <= '0;
      end
    end else if (fire) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window[i] <= last_byte ? 8'd0 : window_shift[i];
      end
    end
  end

endmodule

// ----- hw/rtl/wbps_track.sv -----
// ----------------------------------------------------------------------------
// wbps_track: region byte count and latest match offset
// Counts the bytes of the current region, records the start offset of the
// latest full match and forms the result on the last byte.
// ----------------------------------------------------------------------------
module wbps_track
  import wbps_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LEN_W       = $clog2(MAX_PATTERN_DEF + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic             last_byte,
  input  logic             hit,
  input  logic [LEN_W-1:0] eff_len,
  output wbps_out_t        result
);

  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] bytes_seen_next;
  logic [OFFSET_BITS-1:0] latest_match;
  logic [OFFSET_BITS-1:0] latest_match_next;
  logic                   match_seen;
  logic                   match_seen_next;
  logic [OFFSET_BITS-1:0] len_ext;
  logic                   full_match;

  assign len_ext = OFFSET_BITS'(eff_len);

  // The count saturates at all ones; a match counts once enough bytes arrived.
  always_comb begin
    bytes_seen_next   = (&bytes_seen) ? bytes_seen : bytes_seen + 1'b1;
    full_match        = hit && (bytes_seen_next >= len_ext);
    latest_match_next = full_match ? bytes_seen_next - len_ext : latest_match;
    match_seen_next   = full_match || match_seen;
  end

  // The offset stays zero unless a match was seen in this region.
  assign result.found        = match_seen_next;
  assign result.match_offset = OUT_OFFSET_W'(latest_match_next);

  // Region state: update per transfer, clear after the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen   <= '0;
      latest_match <= '0;
      match_seen   <= 1'b0;
    end else if (fire) begin
      if (last_byte) begin
        bytes_seen   <= '0;
        latest_match <= '0;
        match_seen   <= 1'b0;
      end else begin
        bytes_seen   <= bytes_seen_next;
        latest_match <= latest_match_next;
        match_seen   <= match_seen_next;
      end
    end
  end

endmodule

// ----- hw/rtl/wildcard_byte_pattern_scan.sv -----
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan: wildcard byte signature scanner
// Scans a byte stream for a pattern of up to sixteen bytes with per-byte
// wildcards and reports the offset of the latest match in each region.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the in channel (in_valid / in_stall, payload in_data);
//   last_byte marks the end of a region. One result leaves on the out channel
//   (out_valid / out_stall, payload out_data) for each region, at its last
//   byte: found, and the start offset of the latest match (0 if none).
//   Software sets the pattern, care mask and length through the cfg port
//   while no region is in flight.
//   The result is registered: it is valid in the cycle after the last byte's transfer.
//   Throughput: one byte per cycle while in_stall is low; the window shift, the
//   masked compare and the offset update all complete in the cycle of the transfer.
//   The output register parts the two channels: bytes keep flowing while a
//   result waits, and in_stall rises only while a held result is stalled.
//   Reset clears the window, the region count and the output valid flag, sets
//   the pattern and care mask to zero and the pattern length to one.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  wbps_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output wbps_out_t              out_data
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [CFG_DATA_W-1:0]  pattern_low;
  logic [CFG_DATA_W-1:0]  pattern_high;
  logic [CARE_W-1:0]      care_mask;
  logic [LEN_FIELD_W-1:0] pattern_length;
  logic [LEN_W-1:0]       eff_len;
  wbps_sig_t              sig;
  logic                   in_fire;
  logic                   hit;
  wbps_out_t              result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '0;
      pattern_length <= LEN_FIELD_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:  pattern_low    <= cfg_data;
        CFG_PATTERN_HIGH: pattern_high   <= cfg_data;
        CFG_CARE_MASK:    care_mask      <= cfg_data[CARE_W-1:0];
        CFG_PATTERN_LEN:  pattern_length <= cfg_data[LEN_FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // Length zero acts as one; lengths beyond the window are clipped.
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(pattern_length) > MAX_PATTERN) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(pattern_length);
    end
  end

  assign sig.pattern   = {pattern_high, pattern_low};
  assign sig.care_mask = care_mask;

  // Input transfers stop only while a held result is stalled.
  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  wbps_window #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .fire      (in_fire),
    .data_byte (in_data.data_byte),
    .last_byte (in_data.last_byte),
    .sig       (sig),
    .eff_len   (eff_len),
    .hit       (hit)
  );

  wbps_track #(
    .OFFSET_BITS (OFFSET_BITS),
    .LEN_W       (LEN_W)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .fire      (in_fire),
    .last_byte (in_data.last_byte),
    .hit       (hit),
    .eff_len   (eff_len),
    .result    (result)
  );

  // Output register: loads on a last byte, empties on an output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && in_data.last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.last_byte) begin
      out_data <= result;
    end
  end

endmodule
